// ===== design/dtpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth back-projection package
// Shared constants, register codes and control types of the back-projection
// unit.
// ----------------------------------------------------------------------------
package dtpb_pkg;

   localparam int DEPTH_BITS_DEF = 16;
   localparam int COORD_BITS_DEF = 12;

   localparam int IN_BITS       = 16;
   localparam int OUT_XY_BITS   = 33;
   localparam int OUT_Z_BITS    = 16;
   localparam int OUT_PIX_BITS  = 12;
   localparam int INDEX_BITS    = 24;
   localparam int SIZE_BITS     = 13;
   localparam int CENTER_BITS   = 16;
   localparam int INV_BITS      = 24;
   localparam int INV_SPLIT     = 12;
   localparam int FRAC_BITS     = 4;
   localparam int RSP_PAD_BITS  = 6;
   localparam int RSP_DATA_BITS = 2 * OUT_XY_BITS + OUT_Z_BITS + 2 * OUT_PIX_BITS
                                  + INDEX_BITS + RSP_PAD_BITS;
   localparam int RSP_Z_LSB     = 2 * OUT_XY_BITS;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BITS  = 3;

   localparam logic [REG_SEL_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [REG_SEL_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [REG_SEL_BITS-1:0] REG_CENTER_X     = 3'd2;
   localparam logic [REG_SEL_BITS-1:0] REG_CENTER_Y     = 3'd3;
   localparam logic [REG_SEL_BITS-1:0] REG_INV_FOCAL_X  = 3'd4;
   localparam logic [REG_SEL_BITS-1:0] REG_INV_FOCAL_Y  = 3'd5;

   localparam logic [SIZE_BITS-1:0]   RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [SIZE_BITS-1:0]   RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [CENTER_BITS-1:0] RST_CENTER_X     = 16'd5312;
   localparam logic [CENTER_BITS-1:0] RST_CENTER_Y     = 16'd3701;
   localparam logic [INV_BITS-1:0]    RST_INV_FOCAL_X  = 24'd21098;
   localparam logic [INV_BITS-1:0]    RST_INV_FOCAL_Y  = 24'd21131;

   localparam logic [OUT_XY_BITS-1:0] SAT_POS_VALUE = 33'h0_FFFF_FFFF;
   localparam logic [OUT_XY_BITS-1:0] SAT_NEG_VALUE = 33'h1_0000_0000;

   typedef struct packed {
      logic [SIZE_BITS-1:0]   image_width;
      logic [SIZE_BITS-1:0]   image_height;
      logic [CENTER_BITS-1:0] center_x_q4;
      logic [CENTER_BITS-1:0] center_y_q4;
      logic [INV_BITS-1:0]    inv_focal_x_q24;
      logic [INV_BITS-1:0]    inv_focal_y_q24;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic capture;
      logic load_mag;
      logic load_m;
      logic load_a;
      logic load_b;
      logic load_res;
      logic axis;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic depth_nonzero;
   } sts_type;

endpackage

// ===== design/dtpb_csr.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Register file behind the APB-style port, holding image size, principal
// point and reciprocal focal lengths.
// ----------------------------------------------------------------------------
module dtpb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtpb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dtpb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dtpb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output dtpb_pkg::cfg_type                  cfg
);
   import dtpb_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [REG_SEL_BITS-1:0] sel;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign sel        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_IMAGE_WIDTH:  cfg_in.image_width     = csr_pwdata[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height    = csr_pwdata[SIZE_BITS-1:0];
            REG_CENTER_X:     cfg_in.center_x_q4     = csr_pwdata[CENTER_BITS-1:0];
            REG_CENTER_Y:     cfg_in.center_y_q4     = csr_pwdata[CENTER_BITS-1:0];
            REG_INV_FOCAL_X:  cfg_in.inv_focal_x_q24 = csr_pwdata[INV_BITS-1:0];
            REG_INV_FOCAL_Y:  cfg_in.inv_focal_y_q24 = csr_pwdata[INV_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.image_height);
         REG_CENTER_X:     csr_prdata = CSR_DATA_BITS'(cfg_ff.center_x_q4);
         REG_CENTER_Y:     csr_prdata = CSR_DATA_BITS'(cfg_ff.center_y_q4);
         REG_INV_FOCAL_X:  csr_prdata = CSR_DATA_BITS'(cfg_ff.inv_focal_x_q24);
         REG_INV_FOCAL_Y:  csr_prdata = CSR_DATA_BITS'(cfg_ff.inv_focal_y_q24);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
         cfg_ff.image_height    <= RST_IMAGE_HEIGHT;
         cfg_ff.center_x_q4     <= RST_CENTER_X;
         cfg_ff.center_y_q4     <= RST_CENTER_Y;
         cfg_ff.inv_focal_x_q24 <= RST_INV_FOCAL_X;
         cfg_ff.inv_focal_y_q24 <= RST_INV_FOCAL_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/dtpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Back-projection controller
// Sequences the shared multiply steps for the two axes and owns both
// handshakes.
// ----------------------------------------------------------------------------
module dtpb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  dtpb_pkg::sts_type sts,
   output dtpb_pkg::cmd_type cmd
);
   import dtpb_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAG  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_HI   = 3'd3;
   localparam logic [2:0] ST_LO   = 3'd4;
   localparam logic [2:0] ST_SUM  = 3'd5;
   localparam logic [2:0] ST_PUSH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       axis_ff;
   logic       axis_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cmd          = '0;
      cmd.axis     = axis_ff;
      cmd.advance  = accept;
      cmd.capture  = accept & sts.depth_nonzero;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               axis_in  = 1'b0;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cmd.load_mag = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_m = 1'b1;
            state_in   = ST_HI;
         end
         ST_HI: begin
            cmd.load_a = 1'b1;
            state_in   = ST_LO;
         end
         ST_LO: begin
            cmd.load_b = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.load_res = 1'b1;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = ST_MAG;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/dtpb_datapath.sv =====
// ----------------------------------------------------------------------------
// Back-projection datapath
// Pixel counters, point index, offset magnitude, shared multipliers with
// rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module dtpb_datapath #(
   parameter int DEPTH_BITS = dtpb_pkg::DEPTH_BITS_DEF,
   parameter int COORD_BITS = dtpb_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dtpb_pkg::IN_BITS-1:0]       req_tdata,
   output logic [dtpb_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  dtpb_pkg::cfg_type                  cfg,
   input  dtpb_pkg::cmd_type                  cmd,
   output dtpb_pkg::sts_type                  sts
);
   import dtpb_pkg::*;

   localparam int ZW   = (DEPTH_BITS < IN_BITS) ? DEPTH_BITS : IN_BITS;
   localparam int PW   = COORD_BITS + FRAC_BITS;
   localparam int MW   = (PW > CENTER_BITS) ? PW : CENTER_BITS;
   localparam int DW   = MW + 1;
   localparam int MMW  = MW + ZW;
   localparam int PPW  = MMW + INV_SPLIT;
   localparam int SUMW = PPW + 1;
   localparam int QW   = (MMW + 1 > OUT_XY_BITS + 1) ? MMW + 1 : OUT_XY_BITS + 1;
   localparam int CNTW = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;

   logic [ZW-1:0]          z_req;
   logic [COORD_BITS-1:0]  col_ff, row_ff;
   logic [INDEX_BITS-1:0]  emit_ff;
   logic [COORD_BITS:0]    col_inc, row_inc;
   logic                   col_wrap, row_wrap;
   logic [COORD_BITS-1:0]  col_next, row_next;

   logic [ZW-1:0]          z_ff;
   logic [COORD_BITS-1:0]  pcol_ff, prow_ff;
   logic [INDEX_BITS-1:0]  idx_ff;

   logic [COORD_BITS-1:0]  pix;
   logic [CENTER_BITS-1:0] center;
   logic [INV_BITS-1:0]    inv;
   logic [DW-1:0]          diff;
   logic [DW-1:0]          diff_neg;
   logic                   neg_ff;
   logic [MW-1:0]          mag_ff;
   logic [MMW-1:0]         m_ff;
   logic [PPW-1:0]         a_ff, b_ff;
   logic [SUMW-1:0]        sum;
   logic [QW-1:0]          q;
   logic [OUT_XY_BITS-1:0] res;
   logic [OUT_XY_BITS-1:0] x_ff, y_ff;

   logic [OUT_XY_BITS-1:0]  ox_ff, oy_ff;
   logic [OUT_Z_BITS-1:0]   oz_ff;
   logic [OUT_PIX_BITS-1:0] ocol_ff, orow_ff;
   logic [INDEX_BITS-1:0]   oidx_ff;

   assign z_req             = req_tdata[ZW-1:0];
   assign sts.depth_nonzero = |z_req;

   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign row_wrap = row_inc[COORD_BITS] | (CNTW'(row_inc) >= CNTW'(cfg.image_height));
   assign row_next = row_wrap ? '0 : row_inc[COORD_BITS-1:0];
   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign col_wrap = col_inc[COORD_BITS] | (CNTW'(col_inc) >= CNTW'(cfg.image_width));
   assign col_next = col_wrap ? '0 : col_inc[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         emit_ff <= '0;
      end else if (cmd.advance) begin
         row_ff <= row_next;
         if (row_wrap) begin
            col_ff <= col_next;
         end
         if (row_wrap && col_wrap) begin
            emit_ff <= '0;
         end else if (cmd.capture) begin
            emit_ff <= emit_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         z_ff    <= z_req;
         pcol_ff <= col_ff;
         prow_ff <= row_ff;
         idx_ff  <= emit_ff;
      end
   end

   assign pix      = cmd.axis ? prow_ff : pcol_ff;
   assign center   = cmd.axis ? cfg.center_y_q4 : cfg.center_x_q4;
   assign inv      = cmd.axis ? cfg.inv_focal_y_q24 : cfg.inv_focal_x_q24;
   assign diff     = DW'({pix, {FRAC_BITS{1'b0}}}) - DW'(center);
   assign diff_neg = DW'(0) - diff;

   assign sum = SUMW'(a_ff) + SUMW'(b_ff >> INV_SPLIT) + SUMW'(1 << (INV_SPLIT - 1));
   assign q   = QW'(sum >> INV_SPLIT);

   always_comb begin
      if (neg_ff) begin
         if (q > QW'(SAT_NEG_VALUE)) begin
            res = SAT_NEG_VALUE;
         end else begin
            res = OUT_XY_BITS'(0) - q[OUT_XY_BITS-1:0];
         end
      end else begin
         if (q > QW'(SAT_POS_VALUE)) begin
            res = SAT_POS_VALUE;
         end else begin
            res = q[OUT_XY_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mag) begin
         neg_ff <= diff[DW-1];
         mag_ff <= diff[DW-1] ? diff_neg[MW-1:0] : diff[MW-1:0];
      end
      if (cmd.load_m) begin
         m_ff <= MMW'(mag_ff) * MMW'(z_ff);
      end
      if (cmd.load_a) begin
         a_ff <= PPW'(m_ff) * PPW'(inv[INV_BITS-1:INV_SPLIT]);
      end
      if (cmd.load_b) begin
         b_ff <= PPW'(m_ff) * PPW'(inv[INV_SPLIT-1:0]);
      end
      if (cmd.load_res) begin
         if (cmd.axis) begin
            y_ff <= res;
         end else begin
            x_ff <= res;
         end
      end
      if (cmd.load_out) begin
         ox_ff   <= x_ff;
         oy_ff   <= y_ff;
         oz_ff   <= OUT_Z_BITS'(z_ff);
         ocol_ff <= OUT_PIX_BITS'(pcol_ff);
         orow_ff <= OUT_PIX_BITS'(prow_ff);
         oidx_ff <= idx_ff;
      end
   end

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, oidx_ff, orow_ff, ocol_ff, oz_ff, oy_ff, ox_ff};

endmodule

// ===== design/depth_to_point_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// Depth to point back-projection unit
// Turns a column-major depth image stream into camera-space points through
// a pinhole model with fixed-point reciprocal focal lengths.
// ----------------------------------------------------------------------------
// A zero depth transaction is taken every cycle while the unit is idle and gives no result.
// A nonzero depth gives its result after the shared multiply, round and saturate
// sequence, five steps per axis, run for X and then for Y, later while the previous
// result still waits; the next transaction is taken in the cycle the result appears,
// so a new point is not taken before the previous one has been handed on.
// Synchronous reset restores the register defaults and clears all counters.
module depth_to_point_backprojection_unit #(
   parameter int DEPTH_BITS = dtpb_pkg::DEPTH_BITS_DEF,
   parameter int COORD_BITS = dtpb_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // depth_sample [15:0]
   input  logic [dtpb_pkg::IN_BITS-1:0]       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // point_x [32:0], point_y [65:33], point_z [81:66], pixel_col [93:82],
   // pixel_row [105:94], point_index [129:106], zero fill [135:130]
   output logic [dtpb_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtpb_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dtpb_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dtpb_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import dtpb_pkg::*;

   localparam int ZW = (DEPTH_BITS < IN_BITS) ? DEPTH_BITS : IN_BITS;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   dtpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dtpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dtpb_datapath #(
      .DEPTH_BITS (DEPTH_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts)
   );

   a_zero_depth_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[ZW-1:0] == '0) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("zero depth transaction produced a result");

   a_busy_after_point: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[ZW-1:0] != '0)) |=> !req_tready)
      else $error("new transaction taken while a point is being computed");

   a_result_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_Z_LSB +: OUT_Z_BITS] != '0))
      else $error("result carries a zero depth");

endmodule
